// ===== src/aplgs_pkg.sv =====
// Shared widths, constants and the lattice entry type for the lattice growth step block.
package aplgs_pkg;

    localparam int SITES_DEFAULT = 2048;
    localparam int PICK_W        = 11;
    localparam int POS_W         = 11;
    localparam int HEIGHT_W      = 32;
    localparam int COUNT_W       = 32;
    localparam int GROWTH        = 2;

    typedef struct packed {
        logic                bond;
        logic [HEIGHT_W-1:0] height;
    } entry_t;

endpackage

// ===== src/active_particle_lattice_growth_step_top.sv =====
// Top level of the active particle lattice growth step: one Monte Carlo microstep per transfer.
//
// Each accepted input transfer produces exactly one result transfer. The block takes one item
// per clock cycle unless the output stalls or the clearing pass runs; each result passes the
// input register, then the result register. The bonds and heights live in a single-port-write,
// registered-read memory of SITES entries; the three entries around the particle are held in
// registers and the window slides by one entry per hop, with one memory read and one write-back
// per hop, which is what allows a step every cycle while the output is not stalled. After reset a
// clearing pass writes the initial lattice into the memory; s_ready stays low until it ends.
module active_particle_lattice_growth_step_top
    import aplgs_pkg::*;
#(
    parameter int SITES = SITES_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [PICK_W-1:0]   s_site_pick,
    input  logic [PICK_W-1:0]   s_hop_pick,
    input  logic                s_coin,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_flipped,
    output logic [POS_W-1:0]    m_grown_column,
    output logic [HEIGHT_W-1:0] m_grown_height,
    output logic [COUNT_W-1:0]  m_flip_total,
    output logic [POS_W-1:0]    m_particle_position
);

    localparam int AW = $clog2(SITES);
    localparam int PW = (AW > POS_W) ? AW : POS_W;

    typedef logic [AW-1:0] site_t;

    function automatic site_t right_of(input site_t s);
        right_of = (s == AW'(SITES - 1)) ? '0 : s + AW'(1);
    endfunction

    function automatic site_t left_of(input site_t s);
        left_of = (s == '0) ? AW'(SITES - 1) : s - AW'(1);
    endfunction

    function automatic entry_t reset_entry(input site_t idx);
        entry_t e;
        e.bond   = ~idx[0];
        e.height = HEIGHT_W'(idx[0]);
        reset_entry = e;
    endfunction

    localparam site_t START_SITE = AW'(SITES / 2);

    entry_t lattice_mem [SITES];
    entry_t rd_data_reg;

    logic                in_valid_reg;
    logic [PICK_W-1:0]   in_pick_reg;
    logic [PICK_W-1:0]   in_hop_reg;
    logic                in_coin_reg;

    site_t               walker_reg, walker_next;
    entry_t              ent_m_reg, ent_m_next;
    entry_t              ent_c_reg, ent_c_next;
    entry_t              ent_p_reg, ent_p_next;
    logic                pend_m_reg, pend_m_next;
    logic                pend_p_reg, pend_p_next;
    logic [COUNT_W-1:0]  flip_cnt_reg, flip_cnt_next;
    logic                clr_busy_reg;
    site_t               clr_idx_reg;

    logic                out_valid_reg;
    logic                out_flipped_reg;
    logic [POS_W-1:0]    out_column_reg;
    logic [HEIGHT_W-1:0] out_height_reg;
    logic [COUNT_W-1:0]  out_total_reg;
    logic [POS_W-1:0]    out_pos_reg;

    logic                advance;
    logic                do_step;
    site_t               wl;
    site_t               wr;
    entry_t              eff_m;
    entry_t              eff_p;
    entry_t              new_m;
    entry_t              new_c;
    logic [PW-1:0]       pick_ext;
    logic [PW-1:0]       hop_ext;
    logic [PW-1:0]       w_ext;
    logic [PW-1:0]       wl_ext;
    logic [PW-1:0]       w_next_ext;
    logic                flip_hit;
    logic                hop_hit;
    logic                mv_right;
    logic                mv_left;
    logic [HEIGHT_W:0]   height_sum;
    logic [COUNT_W:0]    count_sum;
    logic                wr_en;
    site_t               wr_addr;
    entry_t              wr_data;
    site_t               rd_addr;

    assign advance = !out_valid_reg || m_ready;
    assign do_step = in_valid_reg && advance;
    assign s_ready = !clr_busy_reg && (!in_valid_reg || advance);

    assign wl    = left_of(walker_reg);
    assign wr    = right_of(walker_reg);
    assign eff_m = pend_m_reg ? rd_data_reg : ent_m_reg;
    assign eff_p = pend_p_reg ? rd_data_reg : ent_p_reg;

    assign pick_ext   = PW'(in_pick_reg);
    assign hop_ext    = PW'(in_hop_reg);
    assign w_ext      = PW'(walker_reg);
    assign wl_ext     = PW'(wl);
    assign w_next_ext = PW'(walker_next);

    assign flip_hit   = (pick_ext == wl_ext) && !eff_m.bond && ent_c_reg.bond;
    assign height_sum = {1'b0, ent_c_reg.height} + (HEIGHT_W + 1)'(GROWTH);
    assign count_sum  = {1'b0, flip_cnt_reg} + (COUNT_W + 1)'(1);

    always_comb begin
        new_m = eff_m;
        new_c = ent_c_reg;
        if (flip_hit) begin
            new_m.bond   = 1'b1;
            new_c.bond   = 1'b0;
            new_c.height = height_sum[HEIGHT_W] ? '1 : height_sum[HEIGHT_W-1:0];
        end
    end

    assign hop_hit  = (hop_ext == w_ext);
    assign mv_right = hop_hit && !new_c.bond && (!new_m.bond || in_coin_reg);
    assign mv_left  = hop_hit && new_m.bond && (new_c.bond || !in_coin_reg);

    always_comb begin
        ent_m_next    = eff_m;
        ent_c_next    = ent_c_reg;
        ent_p_next    = eff_p;
        pend_m_next   = 1'b0;
        pend_p_next   = 1'b0;
        walker_next   = walker_reg;
        flip_cnt_next = flip_cnt_reg;
        wr_en         = 1'b0;
        wr_addr       = wl;
        wr_data       = new_m;
        rd_addr       = right_of(wr);
        if (do_step) begin
            ent_m_next = new_m;
            ent_c_next = new_c;
            if (flip_hit) begin
                flip_cnt_next = count_sum[COUNT_W] ? '1 : count_sum[COUNT_W-1:0];
            end
            if (mv_right) begin
                ent_m_next  = new_c;
                ent_c_next  = eff_p;
                pend_p_next = 1'b1;
                walker_next = wr;
                wr_en       = 1'b1;
                wr_addr     = wl;
                wr_data     = new_m;
                rd_addr     = right_of(wr);
            end else if (mv_left) begin
                ent_p_next  = new_c;
                ent_c_next  = new_m;
                pend_m_next = 1'b1;
                walker_next = wl;
                wr_en       = 1'b1;
                wr_addr     = wr;
                wr_data     = eff_p;
                rd_addr     = left_of(wl);
            end
        end
        if (clr_busy_reg) begin
            wr_en   = 1'b1;
            wr_addr = clr_idx_reg;
            wr_data = reset_entry(clr_idx_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            lattice_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= lattice_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            walker_reg   <= START_SITE;
            ent_m_reg    <= reset_entry(left_of(START_SITE));
            ent_c_reg    <= reset_entry(START_SITE);
            ent_p_reg    <= reset_entry(right_of(START_SITE));
            pend_m_reg   <= 1'b0;
            pend_p_reg   <= 1'b0;
            flip_cnt_reg <= '0;
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end else begin
            walker_reg   <= walker_next;
            ent_m_reg    <= ent_m_next;
            ent_c_reg    <= ent_c_next;
            ent_p_reg    <= ent_p_next;
            pend_m_reg   <= pend_m_next;
            pend_p_reg   <= pend_p_next;
            flip_cnt_reg <= flip_cnt_next;
            if (clr_busy_reg) begin
                clr_idx_reg <= clr_idx_reg + AW'(1);
                if (clr_idx_reg == AW'(SITES - 1)) begin
                    clr_busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_pick_reg <= s_site_pick;
            in_hop_reg  <= s_hop_pick;
            in_coin_reg <= s_coin;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_step) begin
            out_flipped_reg <= flip_hit;
            out_column_reg  <= flip_hit ? w_ext[POS_W-1:0] : '0;
            out_height_reg  <= flip_hit ? new_c.height : '0;
            out_total_reg   <= flip_cnt_next;
            out_pos_reg     <= w_next_ext[POS_W-1:0];
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_flipped           = out_flipped_reg;
    assign m_grown_column      = out_column_reg;
    assign m_grown_height      = out_height_reg;
    assign m_flip_total        = out_total_reg;
    assign m_particle_position = out_pos_reg;

    // Only one window entry can wait on the memory read at a time.
    assert property (@(posedge aclk) disable iff (!aresetn) !(pend_m_reg && pend_p_reg))
        else $error("Both window entries wait on the memory read.");

    assert property (@(posedge aclk) disable iff (!aresetn) walker_reg <= AW'(SITES - 1))
        else $error("Particle site left the lattice.");

    assert property (@(posedge aclk) disable iff (!aresetn) clr_busy_reg |-> !s_ready)
        else $error("Input transfer allowed during the clearing pass.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> flip_cnt_reg >= $past(flip_cnt_reg))
        else $error("Flip count decreased.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_flipped_reg) |-> out_height_reg >= HEIGHT_W'(GROWTH))
        else $error("Grown column reports a height below the growth step.");

endmodule
